FILE: rtl/int_stack_report_parser_assert.svh
// Assertion macros shared by the telemetry stack parser modules.
`ifndef INT_STACK_REPORT_PARSER_ASSERT_SVH
`define INT_STACK_REPORT_PARSER_ASSERT_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ISRP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the next cycle after the antecedent, outside reset.
`define ISRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/isrp_pkg.sv
// Package with the shared types, constants and the hop field table.
package isrp_pkg;

    localparam int MaxHeaderBytesDefault = 256;
    localparam int NumFields = 10;
    localparam int QueueDepth = 4;

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_HDR   = 2'd1,
        PH_DIV   = 2'd2,
        PH_STACK = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        KIND_FLOW_ID   = 4'd0,
        KIND_DEST_AS   = 4'd1,
        KIND_NODE_ID   = 4'd2,
        KIND_INGRESS   = 4'd6,
        KIND_EGRESS    = 4'd7,
        KIND_STATUS    = 4'd12
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_HEADER    = 3'd2,
        ST_NOT_MULT  = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

    // One result transaction as it travels through the queue.
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  hop_index;
        logic [63:0] value;
        logic [2:0]  status;
        logic        last_result;
        logic        scale;
    } result_t;

    function automatic logic [3:0] field_bytes(input logic [3:0] sel);
        logic [3:0] n;
        case (sel)
            4'd4, 4'd5, 4'd6, 4'd9: n = 4'd8;
            default:                n = 4'd4;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/isrp_front.sv
// Front end: takes payload bytes, parses the header and stack, and queues results.
module isrp_front
    import isrp_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MaxHeaderBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        q_push,
    output result_t     q_item0,
    output result_t     q_item1,
    output logic [1:0]  q_count,
    input  logic [$clog2(QueueDepth+1)-1:0] q_free
);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [8:0]  hlen_reg, hlen_next;
    logic [15:0] imask_reg, imask_next;
    logic [15:0] smask_reg, smask_next;
    logic [7:0]  stack_reg, stack_next;
    logic [4:0]  hop_reg, hop_next;
    logic [7:0]  hops_left_reg, hops_left_next;
    logic [3:0]  sel_reg, sel_next;
    logic [63:0] shift_reg, shift_next;
    logic [63:0] fa_reg, fa_next;
    logic [2:0]  err_reg, err_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  hopn_reg, hopn_next;
    logic        done_reg, done_next;
    // Pending status transaction and divider state.
    logic        stat_pend_reg, stat_pend_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  quo_reg, quo_next;
    logic [3:0]  dstep_reg, dstep_next;
    logic        pend_last_reg, pend_last_next;

    logic        accept;
    logic [15:0] o;
    logic [8:0]  o9;
    logic [8:0]  rem_sh;
    logic [4:0]  nxt_idx;
    logic [4:0]  first_idx;

    function automatic logic fon(input logic [15:0] im, input logic [15:0] sm,
                                 input logic [3:0] i);
        logic r;
        if (i < 4'd9) r = im[4'd15 - i];
        else r = sm[0];
        return r;
    endfunction

    function automatic logic [4:0] find_from(input logic [15:0] im,
            input logic [15:0] sm, input logic [4:0] from);
        logic [4:0] r;
        r = 5'(NumFields);
        for (int i = NumFields - 1; i >= 0; i--) begin
            if (5'(i) >= from && fon(im, sm, 4'(i))) r = 5'(i);
        end
        return r;
    endfunction

    assign first_idx = find_from(imask_reg, smask_reg, 5'd0);
    assign nxt_idx   = find_from(imask_reg, smask_reg, 5'(sel_reg) + 5'd1);

    // A byte is taken only when no division or status is pending and room exists.
    assign s_ready = (phase_reg != PH_DIV) && !stat_pend_reg && (q_free >= 2);
    assign accept  = s_valid && s_ready;
    assign o  = pos_reg - 16'd8;
    assign o9 = o[8:0];
    assign rem_sh = {rem_reg, stack_reg[3'd7 - dstep_reg[2:0]]};

    always_comb begin
        phase_next = phase_reg; pos_next = pos_reg; hlen_next = hlen_reg;
        imask_next = imask_reg; smask_next = smask_reg; stack_next = stack_reg;
        hop_next = hop_reg; hops_left_next = hops_left_reg; sel_next = sel_reg;
        shift_next = shift_reg; fa_next = fa_reg; err_next = err_reg;
        cnt_next = cnt_reg; hopn_next = hopn_reg; done_next = done_reg;
        stat_pend_next = stat_pend_reg; rem_next = rem_reg; quo_next = quo_reg;
        dstep_next = dstep_reg; pend_last_next = pend_last_reg;
        q_push = 1'b0; q_count = 2'd0; q_item0 = '0; q_item1 = '0;

        if (phase_reg == PH_DIV) begin
            // Restoring division of the stack size by the hop size, one bit a cycle.
            if (dstep_reg == 4'd8) begin
                if (rem_reg != 8'd0) begin
                    err_next = ST_NOT_MULT; done_next = 1'b1;
                end else if (quo_reg == 8'd0 || first_idx >= 5'(NumFields)) begin
                    done_next = 1'b1;
                end else begin
                    hops_left_next = quo_reg; sel_next = first_idx[3:0];
                    shift_next = '0; cnt_next = '0; hopn_next = '0;
                    phase_next = PH_STACK;
                end
                if (done_next) phase_next = PH_STACK;
                if (pend_last_reg) stat_pend_next = 1'b1;
            end else begin
                if (rem_sh >= {4'd0, hop_reg}) begin
                    rem_next = 8'(rem_sh - {4'd0, hop_reg});
                    quo_next = {quo_reg[6:0], 1'b1};
                end else begin
                    rem_next = rem_sh[7:0];
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                dstep_next = dstep_reg + 4'd1;
            end
        end else if (stat_pend_reg) begin
            q_push = 1'b1; q_count = 2'd1;
            q_item0.kind = KIND_STATUS; q_item0.last_result = 1'b1;
            q_item0.status = (phase_reg == PH_STACK && !done_reg) ? ST_TRUNCATED : err_reg;
            stat_pend_next = 1'b0;
            phase_next = PH_LEN; pos_next = '0; hlen_next = '0; imask_next = '0;
            smask_next = '0; stack_next = '0; hop_next = '0; hops_left_next = '0;
            sel_next = '0; shift_next = '0; fa_next = '0; err_next = '0;
            cnt_next = '0; hopn_next = '0; done_next = 1'b0; pend_last_next = 1'b0;
        end else if (accept) begin
            if (pos_reg != 16'hFFFF) pos_next = pos_reg + 16'd1;
            if (done_reg) begin
                // Bytes after the stack or an error are ignored.
            end else if (phase_reg == PH_LEN) begin
                shift_next = {shift_reg[55:0], s_data_byte};
                if (pos_reg == 16'd7) begin
                    shift_next = '0;
                    if ({shift_reg[55:0], s_data_byte} < 64'd20 ||
                        {shift_reg[55:0], s_data_byte} > 64'(MAX_HEADER_BYTES)) begin
                        err_next = ST_HEADER; done_next = 1'b1;
                    end else begin
                        hlen_next = {shift_reg[0], s_data_byte};
                        fa_next = '0; phase_next = PH_HDR;
                    end
                end
            end else if (phase_reg == PH_HDR) begin
                if (o <= 16'd3 || (o >= 16'd12 && o <= 16'd19))
                    fa_next = {fa_reg[55:0], s_data_byte};
                if (o == 16'd3) begin
                    q_item0.kind = KIND_FLOW_ID;
                    q_item0.value = {44'd0, fa_reg[11:0], s_data_byte};
                    q_count = 2'd1; fa_next = '0;
                end
                if (o == 16'd19) begin
                    q_item0.kind = KIND_DEST_AS;
                    q_item0.value = {fa_reg[55:0], s_data_byte};
                    q_count = 2'd1;
                end
                if (o9 == hlen_reg - 9'd15) stack_next = s_data_byte;
                if (o9 == hlen_reg - 9'd10) hop_next = s_data_byte[4:0];
                if (o9 == hlen_reg - 9'd8) imask_next[15:8] = s_data_byte;
                if (o9 == hlen_reg - 9'd7) imask_next[7:0] = s_data_byte;
                if (o9 == hlen_reg - 9'd4) smask_next[15:8] = s_data_byte;
                if (o9 == hlen_reg - 9'd3) smask_next[7:0] = s_data_byte;
                if (o9 == hlen_reg - 9'd1) begin
                    if (stack_next < 8'd3) begin
                        err_next = ST_HEADER; done_next = 1'b1;
                    end else if (hop_next == 5'd0) begin
                        err_next = ST_NOT_MULT; done_next = 1'b1;
                    end else begin
                        stack_next = stack_next - 8'd3;
                        rem_next = '0; quo_next = '0; dstep_next = '0;
                        phase_next = PH_DIV;
                    end
                end
            end else begin
                shift_next = {shift_reg[55:0], s_data_byte};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_next >= field_bytes(sel_reg)) begin
                    q_item0.kind = 4'(sel_reg) + 4'd2;
                    q_item0.hop_index = hopn_reg;
                    q_item0.value = {shift_reg[55:0], s_data_byte};
                    q_item0.scale = (sel_reg == 4'd4 || sel_reg == 4'd5);
                    q_count = 2'd1;
                    shift_next = '0; cnt_next = '0;
                    if (nxt_idx >= 5'(NumFields)) begin
                        hops_left_next = hops_left_reg - 8'd1;
                        hopn_next = hopn_reg + 8'd1;
                        if (hops_left_reg == 8'd1) done_next = 1'b1;
                        else sel_next = first_idx[3:0];
                    end else begin
                        sel_next = nxt_idx[3:0];
                    end
                end
            end
            if (s_last_byte) begin
                if (phase_next == PH_DIV) begin
                    pend_last_next = 1'b1;
                end else begin
                    q_item1.kind = KIND_STATUS; q_item1.last_result = 1'b1;
                    if (done_next) q_item1.status = err_next;
                    else if (phase_next == PH_LEN) q_item1.status = ST_SHORT;
                    else if (phase_next == PH_HDR) q_item1.status = ST_HEADER;
                    else q_item1.status = ST_TRUNCATED;
                    if (q_count == 2'd0) begin
                        q_item0 = q_item1; q_count = 2'd1;
                    end else begin
                        q_count = 2'd2;
                    end
                    phase_next = PH_LEN; pos_next = '0; hlen_next = '0;
                    imask_next = '0; smask_next = '0; stack_next = '0; hop_next = '0;
                    hops_left_next = '0; sel_next = '0; shift_next = '0; fa_next = '0;
                    err_next = '0; cnt_next = '0; hopn_next = '0; done_next = 1'b0;
                end
            end
            q_push = (q_count != 2'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEN; pos_reg <= '0; hlen_reg <= '0; imask_reg <= '0;
            smask_reg <= '0; stack_reg <= '0; hop_reg <= '0; hops_left_reg <= '0;
            sel_reg <= '0; shift_reg <= '0; fa_reg <= '0; err_reg <= '0;
            cnt_reg <= '0; hopn_reg <= '0; done_reg <= 1'b0; stat_pend_reg <= 1'b0;
            rem_reg <= '0; quo_reg <= '0; dstep_reg <= '0; pend_last_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; pos_reg <= pos_next; hlen_reg <= hlen_next;
            imask_reg <= imask_next; smask_reg <= smask_next; stack_reg <= stack_next;
            hop_reg <= hop_next; hops_left_reg <= hops_left_next; sel_reg <= sel_next;
            shift_reg <= shift_next; fa_reg <= fa_next; err_reg <= err_next;
            cnt_reg <= cnt_next; hopn_reg <= hopn_next; done_reg <= done_next;
            stat_pend_reg <= stat_pend_next; rem_reg <= rem_next; quo_reg <= quo_next;
            dstep_reg <= dstep_next; pend_last_reg <= pend_last_next;
        end
    end

    `include "int_stack_report_parser_assert.svh"
    `ISRP_ASSERT_IMP(a_no_take_in_div, aclk, aresetn, phase_reg == PH_DIV, !accept, "byte taken during division")
    `ISRP_ASSERT_IMP(a_push_room, aclk, aresetn, q_push, q_free >= 2'(q_count), "queue overflow")
    `ISRP_ASSERT_NEXT(a_div_len, aclk, aresetn, phase_reg == PH_DIV && dstep_reg == 4'd8, phase_reg == PH_STACK, "division did not end")

endmodule

FILE: rtl/isrp_back.sv
// Back end: result queue, timestamp scaling and the output register.
module isrp_back
    import isrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_push,
    input  result_t     q_item0,
    input  result_t     q_item1,
    input  logic [1:0]  q_count,
    output logic [$clog2(QueueDepth+1)-1:0] q_free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [7:0]  m_hop_index,
    output logic [63:0] m_value,
    output logic [2:0]  m_status,
    output logic        m_last_result
);

    localparam int AW = $clog2(QueueDepth);
    localparam int CW = $clog2(QueueDepth + 1);

    result_t         mem_reg [QueueDepth];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg, cnt_next;
    result_t         out_reg;
    result_t         head;
    logic            out_valid_reg;
    logic            pop;
    logic [63:0]     scaled;

    // Times 1000 as shifts and adds: 1024 - 16 - 8.
    assign scaled = (mem_reg[rd_reg].value << 10) - (mem_reg[rd_reg].value << 4)
                  - (mem_reg[rd_reg].value << 3);
    assign pop = (cnt_reg != '0) && (!out_valid_reg || m_ready);
    assign q_free = CW'(QueueDepth) - cnt_reg;

    always_comb begin
        head = mem_reg[rd_reg];
        if (head.scale) head.value = scaled;
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (q_push) cnt_next = cnt_next + CW'(q_count);
        if (pop) cnt_next = cnt_next - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            mem_reg[wr_reg] <= q_item0;
            if (q_count == 2'd2) mem_reg[AW'(wr_reg + AW'(1))] <= q_item1;
        end
        if (pop) out_reg <= head;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0; out_valid_reg <= 1'b0;
        end else begin
            if (q_push) wr_reg <= wr_reg + AW'(q_count);
            if (pop) rd_reg <= rd_reg + AW'(1);
            cnt_reg <= cnt_next;
            if (pop) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_hop_index   = out_reg.hop_index;
    assign m_value       = out_reg.value;
    assign m_status      = out_reg.status;
    assign m_last_result = out_reg.last_result;

    `include "int_stack_report_parser_assert.svh"
    `ISRP_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CW'(QueueDepth), "queue count too high")
    `ISRP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value), "output changed while stalled")
    `ISRP_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, pop, cnt_reg != '0, "pop from empty queue")

endmodule

FILE: rtl/int_stack_report_parser.sv
// Top level of the telemetry stack report parser.
// Takes a packet payload one byte per transaction and reports the flow id, the
// destination AS, every selected hop field and a closing status transaction.
// A byte is normally taken every cycle. After the last header byte the block
// stops taking bytes while a bit-serial divider splits the stack into hops, and
// when the payload ends on that last header byte it also holds bytes off while
// it emits the deferred status transaction. A four-entry result queue and an
// output register let the byte side run while results wait; bytes are held
// off whenever fewer than two queue entries are free.
module int_stack_report_parser
    import isrp_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MaxHeaderBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [7:0]  m_hop_index,
    output logic [63:0] m_value,
    output logic [2:0]  m_status,
    output logic        m_last_result
);

    logic       q_push;
    result_t    q_item0, q_item1;
    logic [1:0] q_count;
    logic [$clog2(QueueDepth+1)-1:0] q_free;

    isrp_front #(.MAX_HEADER_BYTES(MAX_HEADER_BYTES)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data_byte, .s_last_byte,
        .q_push, .q_item0, .q_item1, .q_count, .q_free
    );

    isrp_back u_back (
        .aclk, .aresetn, .q_push, .q_item0, .q_item1, .q_count, .q_free,
        .m_valid, .m_ready, .m_kind, .m_hop_index, .m_value, .m_status,
        .m_last_result
    );

endmodule

FILE: test/tb_int_stack_report_parser.sv
// Testbench for the telemetry stack report parser: directed and random packets.
module tb_int_stack_report_parser;
    import isrp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxHdr = MaxHeaderBytesDefault;
    localparam int StallLimit = 20000;
    localparam int ByteTarget = 360;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  hop_index;
        logic [63:0] value;
        logic [2:0]  status;
        logic        last_result;
    } report_t;

    typedef enum logic [1:0] {
        P_LEN   = 2'd0,
        P_HDR   = 2'd1,
        P_STACK = 2'd2,
        P_TAIL  = 2'd3
    } parse_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_kind;
    logic [7:0]  m_hop_index;
    logic [63:0] m_value;
    logic [2:0]  m_status;
    logic        m_last_result;

    int_stack_report_parser dut (.*);

    report_t expected_reports[$];
    int errors = 0;
    int reports_seen = 0;
    int bytes_sent = 0;
    int packets_sent = 0;
    int idle_cycles = 0;
    bit rx_pressure = 1'b1;

    // Predictor state.
    parse_phase_t ph;
    logic [15:0] pos;
    logic [15:0] hlen;
    logic [15:0] imask;
    logic [15:0] dmask;
    logic [7:0]  stk;
    logic [4:0]  hopb;
    logic [7:0]  hleft;
    logic [3:0]  fsel;
    logic [63:0] shreg;
    logic [63:0] fas;
    logic [2:0]  err;
    logic [3:0]  fcnt;
    logic [7:0]  hnum;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int hop_field_len(input int idx);
        return (idx == 4 || idx == 5 || idx == 6 || idx == 9) ? 8 : 4;
    endfunction

    function automatic bit field_enabled(input int idx);
        if (idx < 9) begin
            return imask[15-idx];
        end
        return dmask[0];
    endfunction

    function automatic int next_enabled(input int from);
        for (int i = from; i < NumFields; i++) begin
            if (field_enabled(i)) return i;
        end
        return NumFields;
    endfunction

    task automatic push_report(input int k, input int hop, input logic [63:0] v,
                               input int st, input bit lst);
        report_t r;
        r.kind = k[3:0];
        r.hop_index = hop[7:0];
        r.value = v;
        r.status = st[2:0];
        r.last_result = lst;
        expected_reports.insert(expected_reports.size(), r);
    endtask

    task automatic clear_packet();
        ph = P_LEN;
        pos = '0;
        hlen = '0;
        imask = '0;
        dmask = '0;
        stk = '0;
        hopb = '0;
        hleft = '0;
        fsel = '0;
        shreg = '0;
        fas = '0;
        err = ST_OK;
        fcnt = '0;
        hnum = '0;
    endtask

    task automatic finish_header();
        int stack_sz;
        int first;
        if (stk < 3) begin
            err = ST_HEADER;
            ph = P_TAIL;
            return;
        end
        stack_sz = int'(stk) - 3;
        if (hopb == 0 || (stack_sz % hopb) != 0) begin
            err = ST_NOT_MULT;
            ph = P_TAIL;
            return;
        end
        hleft = 8'(stack_sz / hopb);
        first = next_enabled(0);
        if (hleft == 0 || first >= NumFields) begin
            hleft = 0;
            ph = P_TAIL;
            return;
        end
        fsel = 4'(first);
        shreg = '0;
        fcnt = '0;
        hnum = '0;
        ph = P_STACK;
    endtask

    task automatic predict_byte(input logic [7:0] b, input bit lst);
        int o;
        int h;
        int sel;
        int nxt;
        logic [63:0] v;
        int st;
        case (ph)
            P_LEN: begin
                shreg = (shreg << 8) | b;
                if (pos == 7) begin
                    v = shreg;
                    shreg = '0;
                    if (v < 20 || v > MaxHdr) begin
                        err = ST_HEADER;
                        ph = P_TAIL;
                    end else begin
                        hlen = v[15:0];
                        fas = '0;
                        ph = P_HDR;
                    end
                end
            end
            P_HDR: begin
                o = int'(pos) - 8;
                h = hlen;
                if (o <= 3 || (o >= 12 && o <= 19)) fas = (fas << 8) | b;
                if (o == 3) begin
                    push_report(KIND_FLOW_ID, 0, fas & 64'hFFFFF, ST_OK, 0);
                    fas = '0;
                end
                if (o == 19) push_report(KIND_DEST_AS, 0, fas, ST_OK, 0);
                if (o == h - 15) stk = b;
                if (o == h - 10) hopb = b[4:0];
                if (o == h - 8) imask[15:8] = b;
                if (o == h - 7) imask[7:0] = b;
                if (o == h - 4) dmask[15:8] = b;
                if (o == h - 3) dmask[7:0] = b;
                if (o == h - 1) finish_header();
            end
            P_STACK: begin
                sel = fsel;
                shreg = (shreg << 8) | b;
                fcnt++;
                if (fcnt >= hop_field_len(sel)) begin
                    v = shreg;
                    if (sel == 4 || sel == 5) v = v * 64'd1000;
                    push_report(sel + 2, hnum, v, ST_OK, 0);
                    shreg = '0;
                    fcnt = '0;
                    nxt = next_enabled(sel + 1);
                    if (nxt >= NumFields) begin
                        hleft--;
                        hnum++;
                        if (hleft == 0) ph = P_TAIL;
                        else fsel = 4'(next_enabled(0));
                    end else begin
                        fsel = 4'(nxt);
                    end
                end
            end
            default: ;
        endcase
        if (pos < 16'hFFFF) pos++;
        if (lst) begin
            case (ph)
                P_LEN:   st = ST_SHORT;
                P_HDR:   st = ST_HEADER;
                P_STACK: st = ST_TRUNCATED;
                default: st = err;
            endcase
            push_report(KIND_STATUS, 0, 64'd0, st, 1);
            clear_packet();
        end
    endtask

    // Sends one byte; the sender sometimes inserts a gap before it.
    task automatic send_byte(input logic [7:0] b, input bit lst);
        if ($urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(b, lst);
        bytes_sent++;
        if (lst) packets_sent++;
    endtask

    task automatic send_packet(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Builds a well-formed packet; flaw picks a flaw to inject.
    task automatic build_packet(output logic [7:0] pkt[$], input int hdr_len,
                                input int hop_sz, input int hops,
                                input logic [15:0] im, input logic [15:0] dm,
                                input int cut, input int flaw);
        int stack_sz;
        int nb;
        pkt = {};
        for (int i = 7; i >= 0; i--) begin
            pkt.insert(pkt.size(), 8'((64'(hdr_len)) >> (8 * i)));
        end
        stack_sz = hop_sz * hops;
        for (int o = 0; o < hdr_len; o++) begin
            logic [7:0] b;
            b = 8'($urandom_range(0, 255));
            if (o == hdr_len - 15) b = (flaw == 1) ? 8'($urandom_range(0, 2)) :
                                        8'(stack_sz + 3 + ((flaw == 2) ? 1 : 0));
            if (o == hdr_len - 10) b = {3'($urandom_range(0, 7)), 5'(hop_sz)};
            if (o == hdr_len - 8) b = im[15:8];
            if (o == hdr_len - 7) b = im[7:0];
            if (o == hdr_len - 4) b = dm[15:8];
            if (o == hdr_len - 3) b = dm[7:0];
            pkt.insert(pkt.size(), b);
        end
        nb = 0;
        for (int i = 0; i < NumFields; i++) begin
            if ((i < 9 && im[15-i]) || (i == 9 && dm[0])) nb += hop_field_len(i);
        end
        for (int i = 0; i < nb * hops; i++) begin
            pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 2)) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
        while (cut > 0 && pkt.size() > 1) begin
            void'(pkt.pop_back());
            cut--;
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [7:0] pkt[$];
        // Too short, header length out of range, truncated header.
        pkt = {8'h00, 8'h00, 8'h01};
        send_packet(pkt);
        pkt = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd19, 8'hAA};
        send_packet(pkt);
        pkt = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet(pkt);
        pkt = {8'h00};
        send_packet(pkt);
        build_packet(pkt, 20, 4, 0, 16'h0000, 16'h0000, 10, 0);
        send_packet(pkt);
        // Stack byte under 3, zero hop size, stack not a multiple.
        build_packet(pkt, 20, 4, 0, 16'h8000, 16'h0000, 0, 1);
        send_packet(pkt);
        build_packet(pkt, 20, 0, 0, 16'h8000, 16'h0000, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 20, 4, 1, 16'h8000, 16'h0000, 0, 2);
        send_packet(pkt);
        // All fields selected, truncated stack, and empty masks.
        build_packet(pkt, 20, 31, 1, 16'hFFFF, 16'hFFFF, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 20, 4, 3, 16'h8000, 16'h0000, 7, 0);
        send_packet(pkt);
        build_packet(pkt, 20, 4, 2, 16'h0000, 16'h0000, 0, 0);
        send_packet(pkt);
        wait_drain();
    endtask

    task automatic test_random();
        logic [7:0] pkt[$];
        int hdr;
        int cut;
        int flaw;
        while (bytes_sent < ByteTarget) begin
            if ($urandom_range(0, 9) == 0) begin
                pkt = {};
                repeat ($urandom_range(1, 30)) begin
                    pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
                end
            end else begin
                hdr = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MaxHdr)
                                                   : $urandom_range(20, 28);
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : 0;
                flaw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 0;
                build_packet(pkt, hdr, $urandom_range(1, 31), $urandom_range(0, 4),
                             16'($urandom), 16'($urandom), cut, flaw);
            end
            send_packet(pkt);
        end
        wait_drain();
    endtask

    // Receiver stall pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_pressure) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        report_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("unexpected result kind %0d", m_kind);
                errors++;
            end else begin
                exp_r = expected_reports.pop_front();
                if (m_kind !== exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, m_kind);
                    errors++;
                end
                if (m_hop_index !== exp_r.hop_index) begin
                    $error("hop_index: expected %0d, got %0d", exp_r.hop_index,
                           m_hop_index);
                    errors++;
                end
                if (m_value !== exp_r.value) begin
                    $error("value: expected %h, got %h", exp_r.value, m_value);
                    errors++;
                end
                if (m_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_status);
                    errors++;
                end
                if (m_last_result !== exp_r.last_result) begin
                    $error("last_result: expected %0d, got %0d", exp_r.last_result,
                           m_last_result);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = '0;
        s_last_byte = 1'b0;
        clear_packet();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        rx_pressure = 1'b0;
        repeat (50) @(posedge aclk);
        if (expected_reports.size() != 0) begin
            $error("%0d expected results never arrived", expected_reports.size());
            errors++;
        end
        $display("Sent %0d bytes in %0d packets, checked %0d results.",
                 bytes_sent, packets_sent, reports_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: int_stack_report_parser.f
+incdir+rtl
rtl/isrp_pkg.sv
rtl/isrp_front.sv
rtl/isrp_back.sv
rtl/int_stack_report_parser.sv
test/tb_int_stack_report_parser.sv
